@@ src/fcat_pkg.sv @@
// Package for the fixed-capacity array table: sizes, operation and status codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package fcat_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 3;
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_INSERT = 3'd1,
      OP_POP    = 3'd2,
      OP_DELETE = 3'd3,
      OP_REMOVE = 3'd4,
      OP_FIND   = 3'd5,
      OP_READ   = 3'd6
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_RANGE    = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic reads_left;
      logic in_flight;
      logic found;
   } dp_stat_type;

endpackage

@@ src/fcat_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fcat_ctrl.sv @@
// Controller state machine for the array table: sequences load, walk and finish.
// Depends on fcat_pkg.
`timescale 1ns / 1ps

module fcat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fcat_pkg::dp_stat_type stat,
   output fcat_pkg::dp_cmd_type  cmd,
   output logic                 busy
);

   import fcat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.found || (!stat.reads_left && !stat.in_flight)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_WALK: begin
            cmd.issue = !stat.found;
         end
         S_RESP: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ src/fcat_dp.sv @@
// Datapath for the array table: element RAM, count, walk pointers and result registers.
// Depends on fcat_pkg and fcat_ram.
`timescale 1ns / 1ps

module fcat_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fcat_pkg::dp_cmd_type         cmd,
   output fcat_pkg::dp_stat_type        stat,
   input  logic [fcat_pkg::OP_W-1:0]   req_op,
   input  logic [fcat_pkg::POS_W-1:0]  req_position,
   input  logic [fcat_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic [fcat_pkg::DATA_W-1:0] rsp_read_value,
   output logic [fcat_pkg::IDX_W-1:0]  rsp_found_position,
   output logic [fcat_pkg::STAT_W-1:0] rsp_status,
   output logic [fcat_pkg::CNT_W-1:0]  rsp_element_count,
   output logic                        rsp_vacant
);

   import fcat_pkg::*;

   op_type              op_ff, op_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   status_type          st_ff, st_in;
   logic                ok_ff, ok_in;
   logic                up_ff, up_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rv_ff, rv_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;
   logic [CNT_W-1:0]    w_ff, w_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    fidx_ff, fidx_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [IDX_W-1:0]    rsp_fpos_ff, rsp_fpos_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff;

   status_type          ld_st;
   logic                ld_ok;
   logic                ld_up;
   logic [IDX_W-1:0]    ld_ptr;
   logic [CNT_W-1:0]    ld_rem;
   logic [CMP_W-1:0]    cnt_x;
   logic [CMP_W-1:0]    pos_x;
   logic [CMP_W-1:0]    cap_x;

   logic                issue_go;
   logic                match;
   logic [DATA_W-1:0]   mem_rd;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]   wr_data;

   fcat_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_go),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd)
   );

   // Range and capacity checks and the walk bounds for a new item.
   always_comb begin
      cnt_x  = CMP_W'(count_ff);
      pos_x  = CMP_W'(req_position);
      cap_x  = CMP_W'(CAPACITY);
      ld_st  = STAT_OK;
      ld_ok  = 1'b1;
      ld_up  = 1'b1;
      ld_ptr = '0;
      ld_rem = '0;
      unique case (op_type'(req_op))
         OP_PUSH: begin
            if (cnt_x >= cap_x) begin
               ld_st = STAT_FULL;
               ld_ok = 1'b0;
            end
         end
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               ld_st = STAT_RANGE;
               ld_ok = 1'b0;
            end else if (cnt_x >= cap_x) begin
               ld_st = STAT_FULL;
               ld_ok = 1'b0;
            end else begin
               ld_rem = CNT_W'(cnt_x - pos_x);
               ld_ptr = IDX_W'(cnt_x - CMP_W'(1));
               ld_up  = 1'b0;
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               ld_st = STAT_EMPTY;
               ld_ok = 1'b0;
            end else begin
               ld_rem = CNT_W'(1);
               ld_ptr = IDX_W'(cnt_x - CMP_W'(1));
            end
         end
         OP_DELETE: begin
            if (pos_x >= cnt_x) begin
               ld_st = STAT_RANGE;
               ld_ok = 1'b0;
            end else begin
               ld_rem = CNT_W'(cnt_x - pos_x - CMP_W'(1));
               ld_ptr = IDX_W'(pos_x + CMP_W'(1));
            end
         end
         OP_REMOVE, OP_FIND: begin
            ld_rem = count_ff;
         end
         OP_READ: begin
            if (pos_x >= cnt_x) begin
               ld_st = STAT_RANGE;
               ld_ok = 1'b0;
            end else begin
               ld_rem = CNT_W'(1);
               ld_ptr = IDX_W'(pos_x);
            end
         end
         default: begin
            ld_ok = 1'b0;
         end
      endcase
   end

   assign issue_go = cmd.issue && (rem_ff != '0);
   assign match    = (mem_rd == val_ff);

   always_comb begin
      op_in    = cmd.load ? op_type'(req_op) : op_ff;
      pos_in   = cmd.load ? req_position : pos_ff;
      val_in   = cmd.load ? req_value : val_ff;
      st_in    = cmd.load ? ld_st : st_ff;
      ok_in    = cmd.load ? ld_ok : ok_ff;
      up_in    = cmd.load ? ld_up : up_ff;
      rv_in    = issue_go;
      ridx_in  = issue_go ? ptr_ff : ridx_ff;
      rdata_in = rv_ff ? mem_rd : rdata_ff;

      priority if (cmd.load) begin
         ptr_in = ld_ptr;
         rem_in = ld_rem;
      end else if (issue_go) begin
         ptr_in = up_ff ? ptr_ff + IDX_W'(1) : ptr_ff - IDX_W'(1);
         rem_in = rem_ff - CNT_W'(1);
      end else begin
         ptr_in = ptr_ff;
         rem_in = rem_ff;
      end

      found_in = found_ff;
      fidx_in  = fidx_ff;
      w_in     = w_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         w_in     = '0;
      end else if (rv_ff) begin
         if (op_ff == OP_FIND && match && !found_ff) begin
            found_in = 1'b1;
            fidx_in  = ridx_ff;
         end
         if (op_ff == OP_REMOVE && !match) begin
            w_in = w_ff + CNT_W'(1);
         end
      end
   end

   // One write port: the new word at finish, or the moved word during the walk.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ridx_ff;
      wr_data = mem_rd;
      priority if (cmd.finish && ok_ff && op_ff == OP_PUSH) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(count_ff);
         wr_data = val_ff;
      end else if (cmd.finish && ok_ff && op_ff == OP_INSERT) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(pos_ff);
         wr_data = val_ff;
      end else if (rv_ff) begin
         unique case (op_ff)
            OP_INSERT: begin
               wr_en   = 1'b1;
               wr_addr = ridx_ff + IDX_W'(1);
            end
            OP_DELETE: begin
               wr_en   = 1'b1;
               wr_addr = ridx_ff - IDX_W'(1);
            end
            OP_REMOVE: begin
               wr_en   = !match;
               wr_addr = w_ff[IDX_W-1:0];
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end else begin
         wr_en = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish) begin
         unique case (op_ff)
            OP_PUSH, OP_INSERT: begin
               if (ok_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP, OP_DELETE: begin
               if (ok_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               count_in = w_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_read_value_in = '0;
      if (ok_ff && (op_ff == OP_POP || op_ff == OP_READ)) begin
         rsp_read_value_in = rdata_ff;
      end
      rsp_fpos_in = found_ff ? fidx_ff : '0;
      if (op_ff == OP_FIND) begin
         rsp_status_in = found_ff ? STAT_OK : STAT_NOTFOUND;
      end else begin
         rsp_status_in = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rem_ff       <= '0;
         rv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rv_ff        <= rv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      st_ff    <= st_in;
      ok_ff    <= ok_in;
      up_ff    <= up_in;
      ptr_ff   <= ptr_in;
      ridx_ff  <= ridx_in;
      w_ff     <= w_in;
      fidx_ff  <= fidx_in;
      rdata_ff <= rdata_in;
      if (cmd.finish) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_fpos_ff       <= rsp_fpos_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= count_in;
      end
   end

   assign stat.reads_left   = (rem_ff != '0);
   assign stat.in_flight    = rv_ff;
   assign stat.found        = found_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_element_count  = rsp_count_ff;
   assign rsp_vacant         = (rsp_count_ff == '0);

endmodule

@@ src/fixed_capacity_array_table.sv @@
// Top level of the fixed-capacity array table: controller plus datapath.
// Depends on fcat_pkg, fcat_ctrl and fcat_dp.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_op/position/value      start high while busy low
//   response  rsp_valid, rsp_read_value ... vacant    rsp_valid high, one cycle
//
// Busy is high while the controller walks and responds. No RAM read is needed for push,
// failed checks and empty walks; otherwise the walk issues one read for pop and read, up to
// the element count for insert, delete, remove and find. A find stops issuing reads once
// its first match is seen. One read is issued per cycle on the RAM port during the walk.
// rsp_valid is high in the first cycle with busy low; no new request is taken before the
// response to the last. Reset empties the table. The receiver cannot stall responses.
`timescale 1ns / 1ps

module fixed_capacity_array_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [fcat_pkg::OP_W-1:0]   req_op,
   input  logic [fcat_pkg::POS_W-1:0]  req_position,
   input  logic [fcat_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic [fcat_pkg::DATA_W-1:0] rsp_read_value,
   output logic [fcat_pkg::IDX_W-1:0]  rsp_found_position,
   output logic [fcat_pkg::STAT_W-1:0] rsp_status,
   output logic [fcat_pkg::CNT_W-1:0]  rsp_element_count,
   output logic                        rsp_vacant
);

   import fcat_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fcat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   fcat_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_element_count  (rsp_element_count),
      .rsp_vacant         (rsp_vacant)
   );

endmodule

@@ src/fcat_checker.sv @@
// Port-level checks for the fixed-capacity array table, bound to the top level.
// Depends on fcat_pkg and fixed_capacity_array_table.
`timescale 1ns / 1ps

module fcat_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [fcat_pkg::STAT_W-1:0] rsp_status,
   input logic [fcat_pkg::CNT_W-1:0]  rsp_element_count,
   input logic                        rsp_vacant
);

   import fcat_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_vacant == (rsp_element_count == '0)))
      else $error("empty flag disagrees with element count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_element_count == CNT_W'(CAPACITY)))
      else $error("full status with a table that is not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_element_count <= CNT_W'(CAPACITY)))
      else $error("element count above capacity");

endmodule

bind fixed_capacity_array_table fcat_checker u_fcat_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_element_count (rsp_element_count),
   .rsp_vacant        (rsp_vacant)
);
